[rtl/matrix_state_tanh_recurrence_step_macros.svh]
// Assertion helpers for the recurrence step block.
`ifndef MATRIX_STATE_TANH_RECURRENCE_STEP_MACROS_SVH
`define MATRIX_STATE_TANH_RECURRENCE_STEP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSTR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSTR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mstr_pkg.sv]
`default_nettype none

package mstr_pkg;

  localparam int unsigned N       = 16;
  localparam int unsigned IDX_W   = $clog2(N);
  localparam int unsigned ADDR_W  = $clog2(N * N);
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 28;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [15:0] DECAY_MAX   = 16'd65470;
  localparam logic [15:0] DECAY_RESET = 16'd58982;
  localparam logic [14:0] TANH_SAT    = 15'd16373;

  // tanh(m/8) in Q1.14, m = 0..32
  function automatic logic [14:0] tanh_lut(input logic [5:0] m);
    logic [14:0] y;
    case (m)
      6'd0:  y = 15'd0;     6'd1:  y = 15'd2037;  6'd2:  y = 15'd4013;
      6'd3:  y = 15'd5871;  6'd4:  y = 15'd7571;  6'd5:  y = 15'd9087;
      6'd6:  y = 15'd10406; 6'd7:  y = 15'd11533; 6'd8:  y = 15'd12478;
      6'd9:  y = 15'd13260; 6'd10: y = 15'd13898; 6'd11: y = 15'd14415;
      6'd12: y = 15'd14830; 6'd13: y = 15'd15161; 6'd14: y = 15'd15424;
      6'd15: y = 15'd15631; 6'd16: y = 15'd15795; 6'd17: y = 15'd15923;
      6'd18: y = 15'd16024; 6'd19: y = 15'd16103; 6'd20: y = 15'd16165;
      6'd21: y = 15'd16213; 6'd22: y = 15'd16251; 6'd23: y = 15'd16280;
      6'd24: y = 15'd16303; 6'd25: y = 15'd16321; 6'd26: y = 15'd16335;
      6'd27: y = 15'd16346; 6'd28: y = 15'd16354; 6'd29: y = 15'd16361;
      6'd30: y = 15'd16366; 6'd31: y = 15'd16370; 6'd32: y = 15'd16373;
      default: y = TANH_SAT;
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

[rtl/mstr_mul.sv]
`default_nettype none

// Shared signed multiplier, product registered.
module mstr_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [mstr_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [mstr_pkg::MUL_B_W-1:0] b_i,
  output logic signed [mstr_pkg::PROD_W-1:0]      prod_o
);

  logic signed [mstr_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mstr_pkg::PROD_W'(a_i) * mstr_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[rtl/matrix_state_tanh_recurrence_step.sv]
`default_nettype none

// One timestep of a matrix-state recurrent cell. Sixteen input beats carry the
// key, value and query elements of one step (key in tdata[15:0], value in
// [31:16], query in [47:32], signed Q4.11). Beats are accepted while the block
// is idle; the last one starts the step, and the block drops s_axis_tready
// until the step is done. The step rewrites all 256 state entries, one at a
// time, as tanh(decay*S + value[i]*key[j]), then sends one beat per row:
// row_sum in tdata[15:0] and row_sum^2*sigmoid(row_sum) in tdata[31:16],
// tlast on row 15; each row beat waits on m_axis_tready. No new step's beats
// are taken until the last row is sent. The step's length is set by the one
// multiplier that every product, interpolation and gate goes through in turn.
// The state lives in a 256-entry memory with one valid bit per entry, so reset
// clears it at once. Decay (APB address 0, unsigned Q0.16) saturates at 65470
// on write; write it only while the block is idle.
module matrix_state_tanh_recurrence_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB config
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // key_elem, value_elem, query_elem
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // row_sum, gated_out
  output logic             m_axis_tlast    // last_of_run
);

`include "matrix_state_tanh_recurrence_step_macros.svh"

  localparam int unsigned N      = mstr_pkg::N;
  localparam int unsigned IDX_W  = mstr_pkg::IDX_W;
  localparam int unsigned ADDR_W = mstr_pkg::ADDR_W;
  localparam int unsigned A_W    = mstr_pkg::MUL_A_W;
  localparam int unsigned B_W    = mstr_pkg::MUL_B_W;
  localparam int unsigned P_W    = mstr_pkg::PROD_W;
  localparam int unsigned PRE_W  = 41;

  // 17 states need 5 bits
  typedef enum logic [4:0] {
    S_IDLE, S_U_RD, S_U_M1, S_U_M2, S_U_SUM, S_U_WR,
    S_T_PREP, S_T_MUL, S_T_DONE,
    S_R_RD, S_R_MUL, S_R_ACC, S_R_RND, S_R_SIG, S_R_G1, S_R_G2, S_R_WAIT
  } fsm_e;

  function automatic logic signed [15:0] sat16(input logic signed [P_W-1:0] v);
    logic signed [15:0] r;
    if (v > P_W'(32767))       r = 16'sh7FFF;
    else if (v < -P_W'(32768)) r = 16'sh8000;
    else                       r = v[15:0];
    return r;
  endfunction

  fsm_e state_q, ret_q;
  logic [ADDR_W-1:0] cnt_q;
  logic [IDX_W-1:0]  elem_q;
  logic [15:0]       decay_q;

  logic signed [15:0] key_q [N];
  logic signed [15:0] val_q [N];
  logic signed [15:0] qry_q [N];

  logic [15:0]        mem [N*N];
  logic [15:0]        rdata_q;
  logic               rvalid_q;
  logic [N*N-1:0]     valid_q;

  logic signed [PRE_W-1:0] acc_q, pre_q;
  logic                    neg_q, sat_q;
  logic [26:0]             frac_q;
  logic [14:0]             base_q;
  logic [11:0]             diff_q;
  logic signed [15:0]      y_q, r_q;
  logic [16:0]             sig_q;
  logic                    out_valid_q, out_last_q;
  logic [31:0]             out_data_q;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [P_W-1:0]   prod;
  logic signed [15:0]      s_val;
  logic                    in_beat, cfg_wr;

  // unwritten state entries read as zero
  assign s_val   = rvalid_q ? rdata_q : 16'sd0;
  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_U_M1: begin
        mul_a = A_W'(decay_q);
        mul_b = B_W'(s_val);
      end
      S_U_M2: begin
        mul_a = A_W'(val_q[cnt_q[ADDR_W-1:IDX_W]]);
        mul_b = B_W'(key_q[cnt_q[IDX_W-1:0]]);
      end
      S_T_MUL: begin
        mul_a = A_W'(diff_q);
        mul_b = B_W'(frac_q);
      end
      S_R_MUL: begin
        mul_a = A_W'(s_val);
        mul_b = B_W'(qry_q[cnt_q[IDX_W-1:0]]);
      end
      S_R_SIG: begin
        mul_a = A_W'(r_q);
        mul_b = B_W'(r_q);
      end
      S_R_G1: begin
        mul_a = prod[A_W-1:0];
        mul_b = B_W'(sig_q);
      end
      default: ;
    endcase
  end

  mstr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // state memory: registered read at the sweep address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[cnt_q];
    if (state_q == S_U_WR) begin
      mem[cnt_q] <= y_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      key_q[elem_q] <= s_axis_tdata[15:0];
      val_q[elem_q] <= s_axis_tdata[31:16];
      qry_q[elem_q] <= s_axis_tdata[47:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= mstr_pkg::DECAY_RESET;
    end else if (cfg_wr && !paddr[2]) begin
      decay_q <= (pwdata[15:0] > mstr_pkg::DECAY_MAX) ? mstr_pkg::DECAY_MAX
                                                      : pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {16'd0, decay_q};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [PRE_W-1:0]        mag;
    logic [4:0]              tidx;
    logic [14:0]             y;
    logic signed [P_W-1:0]   rnd;
    logic signed [15:0]      r;
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      elem_q      <= '0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      rvalid_q <= valid_q[cnt_q];
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            if (elem_q == IDX_W'(N - 1)) begin
              elem_q  <= '0;
              cnt_q   <= '0;
              state_q <= S_U_RD;
            end else begin
              elem_q <= elem_q + 1'b1;
            end
          end
        end
        S_U_RD:  state_q <= S_U_M1;
        S_U_M1:  state_q <= S_U_M2;
        S_U_M2: begin
          acc_q   <= prod[PRE_W-1:0];
          state_q <= S_U_SUM;
        end
        S_U_SUM: begin
          // Q.30: decay*S + value*key*256
          pre_q   <= acc_q + (prod[PRE_W-1:0] <<< 8);
          ret_q   <= S_U_WR;
          state_q <= S_T_PREP;
        end
        S_U_WR: begin
          valid_q[cnt_q] <= 1'b1;
          cnt_q          <= cnt_q + 1'b1;
          acc_q          <= '0;
          state_q        <= (cnt_q == ADDR_W'(N * N - 1)) ? S_R_RD : S_U_RD;
        end
        S_T_PREP: begin
          mag    = pre_q[PRE_W-1] ? PRE_W'(-pre_q) : PRE_W'(pre_q);
          tidx   = mag[31:27];
          neg_q  <= pre_q[PRE_W-1];
          sat_q  <= (mag[PRE_W-1:32] != '0);
          frac_q <= mag[26:0];
          base_q <= mstr_pkg::tanh_lut({1'b0, tidx});
          diff_q <= 12'(mstr_pkg::tanh_lut({1'b0, tidx} + 6'd1)
                        - mstr_pkg::tanh_lut({1'b0, tidx}));
          state_q <= S_T_MUL;
        end
        S_T_MUL: state_q <= S_T_DONE;
        S_T_DONE: begin
          y       = sat_q ? mstr_pkg::TANH_SAT : 15'(base_q + 15'(prod[37:27]));
          y_q     <= neg_q ? -$signed({1'b0, y}) : $signed({1'b0, y});
          state_q <= ret_q;
        end
        S_R_RD:  state_q <= S_R_MUL;
        S_R_MUL: state_q <= S_R_ACC;
        S_R_ACC: begin
          acc_q <= acc_q + prod[PRE_W-1:0];
          if (cnt_q[IDX_W-1:0] == IDX_W'(N - 1)) begin
            state_q <= S_R_RND;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_R_RD;
          end
        end
        S_R_RND: begin
          // round half up from Q.25 to Q4.11, then gate input r/2 in Q.30
          rnd     = P_W'(acc_q + PRE_W'(8192)) >>> 14;
          r       = sat16(rnd);
          r_q     <= r;
          pre_q   <= PRE_W'(r) <<< 18;
          ret_q   <= S_R_SIG;
          state_q <= S_T_PREP;
        end
        S_R_SIG: begin
          sig_q   <= 17'(17'sd16384 + 17'(y_q));
          state_q <= S_R_G1;
        end
        S_R_G1:  state_q <= S_R_G2;
        S_R_G2: begin
          rnd         = (prod + P_W'(33554432)) >>> 26;
          out_data_q  <= {sat16(rnd), r_q};
          out_last_q  <= (cnt_q[ADDR_W-1:IDX_W] == IDX_W'(N - 1));
          out_valid_q <= 1'b1;
          state_q     <= S_R_WAIT;
        end
        S_R_WAIT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            acc_q       <= '0;
            cnt_q       <= cnt_q + 1'b1;
            state_q     <= (cnt_q == ADDR_W'(N * N - 1)) ? S_IDLE : S_R_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  `MSTR_ASSERT_NOW(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input open with result pending")
  `MSTR_ASSERT_NEXT(a_step_start, in_beat && (elem_q == IDX_W'(N - 1)), !s_axis_tready, "step did not start")
  `MSTR_ASSERT_NEXT(a_run_end, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not idle after last row")

endmodule

`default_nettype wire
